[rtl/lsi_pkg.sv]
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared widths, register map, job codes and sequencer states of the
// lattice site index block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsi_pkg;

  localparam int LSI_DIMS       = 4;
  localparam int LSI_COORD_BITS = 16;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 32;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;
  localparam int DIV_W   = 32;
  localparam int DEN_W   = 16;
  localparam int JOB_W   = 4;

  localparam logic [2:0] REG_ORIGIN     = 3'd0;
  localparam logic [2:0] REG_EXTENT     = 3'd1;
  localparam logic [2:0] REG_SPLIT      = 3'd2;
  localparam logic [2:0] REG_MERGED     = 3'd3;
  localparam logic [2:0] REG_COUNT      = 3'd4;
  localparam logic [2:0] REG_EVEN_FIRST = 3'd5;
  localparam logic [2:0] REG_EVEN_SITES = 3'd6;

  localparam logic [JOB_W-1:0] JOB_SUBSIZE = 4'd0;
  localparam logic [JOB_W-1:0] JOB_RECIP   = 4'd4;
  localparam logic [JOB_W-1:0] JOB_OFFSET  = 4'd8;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ISSUE,
    SEQ_WAIT
  } seq_state_t;

endpackage

`default_nettype wire

[rtl/lsi_if.sv]
// ----------------------------------------------------------------------------
// lsi_if
// Valid/ready channels for coordinate requests and index results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsi_in_if;
  import lsi_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_0;
  logic [COORD_W-1:0] coord_1;
  logic [COORD_W-1:0] coord_2;
  logic [COORD_W-1:0] coord_3;
  modport source(output valid, output coord_0, output coord_1, output coord_2,
                 output coord_3, input ready);
  modport sink(input valid, input coord_0, input coord_1, input coord_2,
               input coord_3, output ready);
endinterface

interface lsi_out_if;
  import lsi_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] storage_index;
  logic             on_node;
  modport source(output valid, output storage_index, output on_node, input ready);
  modport sink(input valid, input storage_index, input on_node, output ready);
endinterface

`default_nettype wire

[rtl/lsi_sdiv.sv]
// ----------------------------------------------------------------------------
// lsi_sdiv
// Serial restoring divider, one quotient bit per cycle, for the values
// derived from the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_sdiv (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lsi_pkg::DIV_W-1:0] num,
  input  wire logic [lsi_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic      [lsi_pkg::DIV_W-1:0] quo
);
  import lsi_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DIV_W-1:0] q_r;
  logic [DEN_W:0]   trial;
  logic             fit;

  assign trial = {rem_r, q_r[DIV_W-1]};
  assign fit   = trial >= {1'b0, den_r};
  assign done  = run_r && (cnt_r == '0);
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(DIV_W);
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      q_r   <= num;
    end else if (run_r && (cnt_r != '0)) begin
      rem_r <= fit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], fit};
    end
  end

endmodule

`default_nettype wire

[rtl/lattice_site_index.sv]
// ----------------------------------------------------------------------------
// lattice_site_index
// On-node test and storage index of a lattice site under a vector-subnode
// layout with optional even-first ordering.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  in_req    sink       valid/ready      coord_0..coord_3
//  out_res   source     valid/ready      storage_index, on_node
//  cfg_*     slave      APB, pready = 1  seven registers at 8*i
//
//  Ten register stages; one request per cycle unless stalled or busy.
//  Divisions by the subsize use reciprocals held from the configuration.
//  After reset and after every register write a serial divider rebuilds the
//  subsizes, reciprocals and odd offset while in_req.ready is held low.
//  A stalled output freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_site_index #(
  parameter int DIMS       = lsi_pkg::LSI_DIMS,
  parameter int COORD_BITS = lsi_pkg::LSI_COORD_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lsi_in_if.sink                          in_req,
  lsi_out_if.source                       out_res,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [lsi_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [lsi_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [lsi_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import lsi_pkg::*;

  localparam logic [COORD_W-1:0] CMASK = COORD_W'((32'd1 << COORD_BITS) - 1);

  // configuration registers
  logic [63:0] origin_r, extent_r;
  logic [31:0] split_r, even_sites_r;
  logic [1:0]  merged_r;
  logic [8:0]  count_r;
  logic        even_first_r;

  logic        wr;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx       = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r     <= 64'd0;
      extent_r     <= 64'h0001_0001_0001_0001;
      split_r      <= 32'h0101_0101;
      merged_r     <= 2'd0;
      count_r      <= 9'd1;
      even_first_r <= 1'b0;
      even_sites_r <= 32'd0;
    end else if (wr) begin
      unique case (ridx)
        REG_ORIGIN:     origin_r     <= cfg_pwdata;
        REG_EXTENT:     extent_r     <= cfg_pwdata;
        REG_SPLIT:      split_r      <= cfg_pwdata[31:0];
        REG_MERGED:     merged_r     <= cfg_pwdata[1:0];
        REG_COUNT:      count_r      <= cfg_pwdata[8:0];
        REG_EVEN_FIRST: even_first_r <= cfg_pwdata[0];
        REG_EVEN_SITES: even_sites_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ORIGIN:     cfg_prdata = origin_r;
      REG_EXTENT:     cfg_prdata = extent_r;
      REG_SPLIT:      cfg_prdata = {32'd0, split_r};
      REG_MERGED:     cfg_prdata = {62'd0, merged_r};
      REG_COUNT:      cfg_prdata = {55'd0, count_r};
      REG_EVEN_FIRST: cfg_prdata = {63'd0, even_first_r};
      REG_EVEN_SITES: cfg_prdata = {32'd0, even_sites_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // fixed-up configuration values
  logic [7:0] split_f [4];
  logic [8:0] count_f;
  logic       has_merged;

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      split_f[d] = (split_r[8*d +: 8] == 8'd0) ? 8'd1 : split_r[8*d +: 8];
    end
  end
  assign count_f    = (count_r == 9'd0) ? 9'd1 : count_r;
  assign has_merged = 32'(merged_r) < DIMS;

  // derived values, rebuilt by the sequencer
  logic [15:0] ss_r [4];
  logic [16:0] rc_r [4];
  logic [31:0] off_r;

  seq_state_t       st_r, st_nxt;
  logic [JOB_W-1:0] job_r, job_nxt;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             busy;

  lsi_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign busy = st_r != SEQ_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= SEQ_ISSUE;
      job_r <= '0;
    end else begin
      st_r  <= st_nxt;
      job_r <= job_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    job_nxt   = job_r;
    div_start = 1'b0;
    unique case (st_r)
      SEQ_IDLE: ;
      SEQ_ISSUE: begin
        div_start = 1'b1;
        st_nxt    = SEQ_WAIT;
      end
      SEQ_WAIT: begin
        if (div_done) begin
          if (job_r == JOB_OFFSET) begin
            st_nxt = SEQ_IDLE;
          end else begin
            job_nxt = job_r + 1'b1;
            st_nxt  = SEQ_ISSUE;
          end
        end
      end
      default: st_nxt = SEQ_IDLE;
    endcase
    if (wr) begin
      st_nxt  = SEQ_ISSUE;
      job_nxt = '0;
    end
  end

  always_comb begin
    priority if (job_r < JOB_RECIP) begin
      div_num = {16'd0, extent_r[16*job_r[1:0] +: 16]};
      div_den = {8'd0, split_f[job_r[1:0]]};
    end else if (job_r < JOB_OFFSET) begin
      div_num = 32'h0001_0000;
      div_den = ss_r[job_r[1:0]];
    end else begin
      div_num = even_sites_r;
      div_den = {7'd0, count_f};
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == SEQ_WAIT && div_done && !wr) begin
      priority if (job_r < JOB_RECIP) begin
        ss_r[job_r[1:0]] <= (div_quo[15:0] == 16'd0) ? 16'd1 : div_quo[15:0];
      end else if (job_r < JOB_OFFSET) begin
        rc_r[job_r[1:0]] <= div_quo[16:0];
      end else begin
        off_r <= div_quo;
      end
    end
  end

  // pipeline
  localparam int NST = 10;

  logic           vld_r [1:NST];
  logic           en;
  logic [15:0]    coord [4];

  assign en            = !vld_r[NST] || out_res.ready;
  assign in_req.ready  = en && !busy;
  assign coord[0]      = in_req.coord_0;
  assign coord[1]      = in_req.coord_1;
  assign coord[2]      = in_req.coord_2;
  assign coord[3]      = in_req.coord_3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_req.valid && !busy;
      for (int s = 2; s <= NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // stage 1: local offsets and box test
  logic [15:0] loc1_nxt [4];
  logic        ins1_nxt, par1_nxt;
  logic [15:0] loc1_r [4];
  logic        ins1_r, par1_r;

  always_comb begin
    logic [15:0] c, lo, ext, dl;
    ins1_nxt = 1'b1;
    par1_nxt = 1'b0;
    for (int d = 0; d < 4; d++) begin
      c   = coord[d] & CMASK;
      lo  = origin_r[16*d +: 16];
      ext = extent_r[16*d +: 16];
      dl  = c - lo;
      loc1_nxt[d] = 16'd0;
      if (d < DIMS) begin
        par1_nxt = par1_nxt ^ c[0];
        if (c < lo || dl >= ext) ins1_nxt = 1'b0;
        loc1_nxt[d] = dl;
      end
    end
  end

  // stage 2: multiply by the reciprocal
  logic [15:0] loc2_r [4];
  logic [32:0] p2_r [4];
  logic        ins2_r, par2_r;

  // stage 3: quotient estimate times subsize
  logic [15:0] loc3_r [4];
  logic [15:0] q03_r [4];
  logic [31:0] m3_r [4];
  logic        ins3_r, par3_r;

  // stage 4: correct quotient and remainder
  logic [15:0] q4_r [4], r4_r [4];
  logic        ins4_r, par4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 4; d++) begin
        loc1_r[d] <= loc1_nxt[d];
        loc2_r[d] <= loc1_r[d];
        p2_r[d]   <= {1'b0, loc1_r[d]} * {16'd0, rc_r[d]};
        loc3_r[d] <= loc2_r[d];
        q03_r[d]  <= p2_r[d][31:16];
        m3_r[d]   <= p2_r[d][31:16] * ss_r[d];
      end
      ins1_r <= ins1_nxt;  par1_r <= par1_nxt;
      ins2_r <= ins1_r;    par2_r <= par1_r;
      ins3_r <= ins2_r;    par3_r <= par2_r;
      ins4_r <= ins3_r;    par4_r <= par3_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] rem;
    if (en) begin
      for (int d = 0; d < 4; d++) begin
        rem = {1'b0, loc3_r[d]} - m3_r[d][16:0];
        if (rem >= {1'b0, ss_r[d]}) begin
          q4_r[d] <= q03_r[d] + 16'd1;
          r4_r[d] <= 16'(rem - {1'b0, ss_r[d]});
        end else begin
          q4_r[d] <= q03_r[d];
          r4_r[d] <= rem[15:0];
        end
      end
    end
  end

  // stages 5..8: fold in one dimension each, slowest first
  logic [31:0] sub_r [4], run_r [4];
  logic [15:0] qh_r [4][4], rh_r [4][4];
  logic        insh_r [4], parh_r [4];

  logic [31:0] sub_in [4], run_in [4], sub_nxt [4], run_nxt [4];
  logic [15:0] qh_in [4][4], rh_in [4][4];
  logic        insh_in [4], parh_in [4];

  always_comb begin
    logic [15:0] sm;
    int          d;
    sm = q4_r[merged_r];
    for (int k = 0; k < 4; k++) begin
      d = 3 - k;
      if (k == 0) begin
        sub_in[k]  = has_merged ?
          32'(sm >> 1) + (sm[0] ? 32'(split_f[merged_r] >> 1) : 32'd0) : 32'd0;
        run_in[k]  = 32'd0;
        qh_in[k]   = q4_r;
        rh_in[k]   = r4_r;
        insh_in[k] = ins4_r;
        parh_in[k] = par4_r;
      end else begin
        sub_in[k]  = sub_r[k-1];
        run_in[k]  = run_r[k-1];
        qh_in[k]   = qh_r[k-1];
        rh_in[k]   = rh_r[k-1];
        insh_in[k] = insh_r[k-1];
        parh_in[k] = parh_r[k-1];
      end
      sub_nxt[k] = sub_in[k];
      run_nxt[k] = run_in[k];
      if (d < DIMS) begin
        run_nxt[k] = 32'(run_in[k] * ss_r[d]) + 32'(rh_in[k][d]);
        if (!(has_merged && 32'(merged_r) == d)) begin
          sub_nxt[k] = 32'(sub_in[k] * split_f[d]) + 32'(qh_in[k][d]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sub_r[k]  <= sub_nxt[k];
        run_r[k]  <= run_nxt[k];
        qh_r[k]   <= qh_in[k];
        rh_r[k]   <= rh_in[k];
        insh_r[k] <= insh_in[k];
        parh_r[k] <= parh_in[k];
      end
    end
  end

  // stage 9: even-first reordering
  logic [31:0] sub9_r, run9_r;
  logic        ins9_r;

  // stage 10: final index
  logic [31:0] idx_r;
  logic        on_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sub9_r <= sub_r[3];
      ins9_r <= insh_r[3];
      if (even_first_r) begin
        run9_r <= (run_r[3] >> 1) + (parh_r[3] ? off_r : 32'd0);
      end else begin
        run9_r <= run_r[3];
      end
      on_r  <= ins9_r;
      idx_r <= ins9_r ? sub9_r + 32'(run9_r * count_f) : 32'd0;
    end
  end

  assign out_res.valid         = vld_r[NST];
  assign out_res.storage_index = idx_r;
  assign out_res.on_node       = on_r;

endmodule

`default_nettype wire

[sim/lattice_site_index_tb.sv]
// ----------------------------------------------------------------------------
// lattice_site_index_tb
// Drives coordinate requests through lattice_site_index under a series of
// node box and subnode layouts, predicts each on-node flag and storage index
// and compares every result in order. A short directed table comes first,
// then random phases with reprogrammed registers and random handshake gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_site_index_tb;
  import lsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] c3;
    logic [15:0] c2;
    logic [15:0] c1;
    logic [15:0] c0;
  } coord_req_t;

  typedef struct packed {
    logic [31:0] storage_index;
    logic        on_node;
  } site_res_t;

  typedef struct packed {
    coord_req_t req;
    logic       typed;
    site_res_t  res;
  } req_row_t;

  typedef struct packed {
    logic [63:0] origin;
    logic [63:0] extent;
    logic [31:0] split;
    logic [1:0]  merged;
    logic [8:0]  count;
    logic        even_first;
    logic [31:0] even_sites;
  } layout_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  lsi_in_if  in_ch();
  lsi_out_if out_ch();

  lattice_site_index dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_ch), .out_res(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  layout_t    lay;
  req_row_t   req_q[$];
  site_res_t  site_exp_q[$];
  req_row_t   cur_row;
  bit         quiet;
  int         fails;
  int         n_req, n_res, n_on;
  longint     cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] split_of(layout_t l, int d);
    logic [31:0] v;
    v = {24'd0, l.split[8*d +: 8]};
    return (v == 0) ? 32'd1 : v;
  endfunction

  function automatic logic [31:0] subsize_of(layout_t l, int d);
    logic [31:0] v;
    v = {16'd0, l.extent[16*d +: 16]} / split_of(l, d);
    return (v == 0) ? 32'd1 : v;
  endfunction

  function automatic site_res_t predict_site(layout_t l, coord_req_t r);
    logic [31:0] loc[4];
    logic [31:0] c, lo, ext, psum, cnt, sub, run, s, ss;
    logic        in_box;
    int          m;
    site_res_t   o;
    psum = 0;
    in_box = 1'b1;
    for (int d = 0; d < 4; d++) begin
      c = {16'd0, r[16*d +: 16]};
      lo = {16'd0, l.origin[16*d +: 16]};
      ext = {16'd0, l.extent[16*d +: 16]};
      psum = psum + c;
      if (c < lo || c - lo >= ext) begin
        in_box = 1'b0;
        loc[d] = 0;
      end else begin
        loc[d] = c - lo;
      end
    end
    if (!in_box) begin
      o.storage_index = 0;
      o.on_node = 1'b0;
      return o;
    end
    cnt = (l.count == 0) ? 32'd1 : {23'd0, l.count};
    m = int'(l.merged);
    s = loc[m] / subsize_of(l, m);
    sub = s / 2 + (s % 2) * (split_of(l, m) / 2);
    run = 0;
    for (int d = 3; d >= 0; d--) begin
      ss = subsize_of(l, d);
      if (d != m) sub = sub * split_of(l, d) + loc[d] / ss;
      run = run * ss + loc[d] % ss;
    end
    if (l.even_first) begin
      if (psum[0] == 1'b0) run = run / 2;
      else run = run / 2 + l.even_sites / cnt;
    end
    o.storage_index = sub + cnt * run;
    o.on_node = 1'b1;
    return o;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic load_layout(layout_t l);
    reg_write(REG_ORIGIN, l.origin);
    reg_write(REG_EXTENT, l.extent);
    reg_write(REG_SPLIT, {32'd0, l.split});
    reg_write(REG_MERGED, {62'd0, l.merged});
    reg_write(REG_COUNT, {55'd0, l.count});
    reg_write(REG_EVEN_FIRST, {63'd0, l.even_first});
    reg_write(REG_EVEN_SITES, {32'd0, l.even_sites});
    lay = l;
  endtask

  task automatic drain();
    while (req_q.size() != 0 || in_ch.valid || site_exp_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic layout_t random_layout();
    layout_t l;
    for (int d = 0; d < 4; d++) begin
      l.origin[16*d +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 64));
      l.extent[16*d +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(1, 12));
      l.split[8*d +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 4));
    end
    l.merged = 2'($urandom_range(0, 3));
    l.count = 9'($urandom);
    l.even_first = 1'($urandom);
    l.even_sites = $urandom;
    return l;
  endfunction

  function automatic coord_req_t random_req(layout_t l);
    coord_req_t r;
    for (int d = 0; d < 4; d++) begin
      if ($urandom_range(0, 9) == 0) r[16*d +: 16] = 16'($urandom);
      else r[16*d +: 16] = l.origin[16*d +: 16] + 16'($urandom_range(0, 12))
                           - 16'($urandom_range(0, 1));
    end
    return r;
  endfunction

  // input side: hold request until accepted, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        site_exp_q.insert(site_exp_q.size(),
                          cur_row.typed ? cur_row.res : predict_site(lay, cur_row.req));
        n_req++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (req_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
          cur_row = req_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.coord_0 <= cur_row.req.c0;
          in_ch.coord_1 <= cur_row.req.c1;
          in_ch.coord_2 <= cur_row.req.c2;
          in_ch.coord_3 <= cur_row.req.c3;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    site_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (site_exp_q.size() == 0) begin
          $error("unexpected result: storage_index %0h on_node %0b",
                 out_ch.storage_index, out_ch.on_node);
          fails++;
        end else begin
          e = site_exp_q.pop_front();
          n_res++;
          if (e.on_node) n_on++;
          if (out_ch.on_node !== e.on_node) begin
            $error("on_node expected %0b actual %0b", e.on_node, out_ch.on_node);
            fails++;
          end
          if (out_ch.storage_index !== e.storage_index) begin
            $error("storage_index expected %0h actual %0h",
                   e.storage_index, out_ch.storage_index);
            fails++;
          end
        end
      end
      out_ch.ready <= quiet || $urandom_range(0, 99) >= 6;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  req_row_t dir_tab[$];
  layout_t  dir_lay[3];
  int       dir_grp[$];

  function automatic req_row_t mk(int a, int b, int c, int d, int t, int idx, int on);
    req_row_t r;
    r.req = {16'(d), 16'(c), 16'(b), 16'(a)};
    r.typed = 1'(t);
    r.res = {32'(idx), 1'(on)};
    return r;
  endfunction

  task automatic add_row(int g, req_row_t r);
    dir_tab.insert(dir_tab.size(), r);
    dir_grp.insert(dir_grp.size(), g);
  endtask

  initial begin
    layout_t  l;
    req_row_t row;
    fails = 0; n_req = 0; n_res = 0; n_on = 0; cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.coord_0 = '0; in_ch.coord_1 = '0; in_ch.coord_2 = '0; in_ch.coord_3 = '0;
    out_ch.ready = 1'b0;
    lay = '{origin: 64'd0, extent: 64'h0001_0001_0001_0001, split: 32'h0101_0101,
            merged: 2'd0, count: 9'd1, even_first: 1'b0, even_sites: 32'd0};
    dir_lay[0] = lay;
    dir_lay[1] = '{origin: {16'd40, 16'd30, 16'd20, 16'd10},
                   extent: {16'd8, 16'd4, 16'd6, 16'd4}, split: 32'h0200_0302,
                   merged: 2'd1, count: 9'd12, even_first: 1'b1, even_sites: 32'd2000};
    dir_lay[2] = '{origin: 64'd0, extent: 64'hFFFF_FFFF_FFFF_FFFF, split: 32'hFFFF_FFFF,
                   merged: 2'd3, count: 9'd0, even_first: 1'b1,
                   even_sites: 32'hFFFF_FFFF};
    // reset layout
    add_row(0, mk(0, 0, 0, 0, 1, 0, 1));
    add_row(0, mk(1, 0, 0, 0, 1, 0, 0));
    add_row(0, mk(0, 0, 0, 1, 1, 0, 0));
    add_row(0, mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0));
    // uneven split, zero split, interleave, odd offset
    add_row(1, mk(10, 20, 30, 40, 1, 0, 1));
    add_row(1, mk(9, 20, 30, 40, 1, 0, 0));
    add_row(1, mk(14, 20, 30, 40, 1, 0, 0));
    add_row(1, mk(10, 26, 30, 40, 1, 0, 0));
    add_row(1, mk(10, 20, 30, 48, 1, 0, 0));
    add_row(1, mk(11, 20, 30, 40, 0, 0, 0));
    add_row(1, mk(13, 25, 33, 47, 0, 0, 0));
    add_row(1, mk(12, 23, 31, 45, 0, 0, 0));
    add_row(1, mk(10, 21, 32, 43, 0, 0, 0));
    // full extents, split above extent-per-subnode, zero count
    add_row(2, mk(0, 0, 0, 0, 1, 0, 1));
    add_row(2, mk(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 0, 0, 0));
    add_row(2, mk(16'hFFFF, 0, 0, 0, 1, 0, 0));
    add_row(2, mk(16'hAAAA, 16'h5555, 16'h1234, 16'hFEDC, 0, 0, 0));
    add_row(2, mk(16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 0, 0, 0));
    add_row(2, mk(1, 0, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int g = 0; g < 3; g++) begin
      if (g != 0) load_layout(dir_lay[g]);
      for (int i = 0; i < dir_tab.size(); i++)
        if (dir_grp[i] == g) req_q.insert(req_q.size(), dir_tab[i]);
      drain();
    end

    for (int p = 0; p < 10; p++) begin
      l = random_layout();
      if (p == 0) l.count = 9'd256;
      if (p == 1) l.count = 9'd511;
      load_layout(l);
      quiet = (p == 4);
      for (int i = 0; i < 130; i++) begin
        row.req = random_req(lay);
        row.typed = 1'b0;
        row.res = '0;
        req_q.insert(req_q.size(), row);
      end
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d requests, %0d results, %0d on node, 13 register layouts",
             n_req, n_res, n_on);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
